// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the RTL; they expect clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising edge outside reset.
`define ASSERT_CLK(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks that a condition never holds outside reset.
`define ASSERT_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ----- rtl/core/lpht_pkg.sv -----
// Package with the types and constants of the linear probing hash table.
package lpht_pkg;

  localparam int TABLE_SLOTS  = 8;
  localparam int SLOT_W       = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int KEY_W        = 31;
  localparam int DATA_W       = 64;
  localparam int SLOT_FIELD_W = 3;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_SEARCH = 1'b1;

  localparam logic [1:0] ST_INSERTED  = 2'd0;
  localparam logic [1:0] ST_FOUND     = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  typedef struct packed {
    logic              kind;
    logic [KEY_W-1:0]  key;
    logic [DATA_W-1:0] payload;
  } req_t;

  typedef struct packed {
    logic [1:0]              status;
    logic [SLOT_FIELD_W-1:0] slot;
    logic [DATA_W-1:0]       data_out;
  } res_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] addr;
    logic [KEY_W-1:0]  key;
    logic [DATA_W-1:0] data;
  } wr_t;

  typedef struct packed {
    logic              valid;
    logic [KEY_W-1:0]  key;
    logic [DATA_W-1:0] data;
  } rd_t;

  typedef struct packed {
    logic idle;
    logic done;
  } ctrl_stat_t;

endpackage

// ----- rtl/core/lpht_store.sv -----
// Slot storage: valid bits in flip-flops, keys and payloads in a memory with a registered read.
module lpht_store import lpht_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  wr_t               wr,
  input  logic [SLOT_W-1:0] rd_addr,
  output rd_t               rd
);

  logic [TABLE_SLOTS-1:0] slot_valid;
  logic [KEY_W-1:0]       key_mem  [TABLE_SLOTS];
  logic [DATA_W-1:0]      data_mem [TABLE_SLOTS];

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
    end else if (wr.en) begin
      slot_valid[wr.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      key_mem[wr.addr]  <= wr.key;
      data_mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd.valid <= 1'b0;
    end else begin
      rd.valid <= slot_valid[rd_addr];
    end
    rd.key  <= key_mem[rd_addr];
    rd.data <= data_mem[rd_addr];
  end

endmodule

// ----- rtl/core/lpht_ctrl.sv -----
// Probe sequencer: hashes the key, then steps one slot per cycle through a shared compare.
module lpht_ctrl import lpht_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  req_t              req,
  input  logic              take,
  input  rd_t               rd,
  output logic [SLOT_W-1:0] rd_addr,
  output wr_t               wr,
  output res_t              result,
  output ctrl_stat_t        stat
);

  typedef enum logic [1:0] {S_IDLE, S_PROBE, S_DONE} state_t;

  state_t            state;
  logic              kind_q;
  logic [KEY_W-1:0]  key_q;
  logic [DATA_W-1:0] pay_q;
  logic [SLOT_W-1:0] pos;
  logic [SLOT_W-1:0] cnt;

  logic [SLOT_W-1:0] home;
  logic [SLOT_W-1:0] pos_inc;
  logic              last;
  logic              match;
  logic              finish;
  res_t              res_next;

  assign home    = SLOT_W'(req.key % TABLE_SLOTS);
  assign pos_inc = (pos == SLOT_W'(TABLE_SLOTS - 1)) ? '0 : pos + 1'b1;
  assign last    = (cnt == SLOT_W'(TABLE_SLOTS - 1));
  assign match   = rd.valid && (rd.key == key_q);
  assign rd_addr = (state == S_IDLE) ? home : pos_inc;

  assign stat.idle = (state == S_IDLE);
  assign stat.done = (state == S_DONE);

  always_comb begin
    res_next = '0;
    finish   = 1'b0;
    wr       = '0;
    wr.addr  = pos;
    wr.key   = key_q;
    wr.data  = pay_q;
    if (kind_q == KIND_INSERT) begin
      priority if (!rd.valid) begin
        finish          = 1'b1;
        wr.en           = (state == S_PROBE);
        res_next.status = ST_INSERTED;
        res_next.slot   = SLOT_FIELD_W'(pos);
      end else if (last) begin
        finish          = 1'b1;
        res_next.status = ST_FULL;
      end else begin
        finish          = 1'b0;
      end
    end else begin
      priority if (!rd.valid) begin
        finish          = 1'b1;
        res_next.status = ST_NOT_FOUND;
      end else if (match) begin
        finish            = 1'b1;
        res_next.status   = ST_FOUND;
        res_next.slot     = SLOT_FIELD_W'(pos);
        res_next.data_out = rd.data;
      end else if (last) begin
        finish          = 1'b1;
        res_next.status = ST_NOT_FOUND;
      end else begin
        finish          = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            kind_q <= req.kind;
            key_q  <= req.key;
            pay_q  <= req.payload;
            pos    <= home;
            cnt    <= '0;
            state  <= S_PROBE;
          end
        end
        S_PROBE: begin
          if (finish) begin
            result <= res_next;
            state  <= S_DONE;
          end else begin
            pos <= pos_inc;
            cnt <= cnt + 1'b1;
          end
        end
        S_DONE: begin
          if (take) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/core/linear_probe_hash_table.sv -----
// Top level of the linear probing hash table with its output register.
// A new request is accepted only while the sequencer is idle, after the previous one is through:
// the sequencer probes the slots visited, hands its result to the output register once that
// register is free, and returns to idle to take the next request. The probe pace is set by the
// single compare unit, which checks one slot per cycle through the registered read port of
// the slot memory. A result may wait in the output register while the next request runs;
// the sequencer holds its own result while an earlier one still waits there.
`include "assert_macros.svh"

module linear_probe_hash_table import lpht_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic res_valid,
  input  logic res_ready,
  output res_t res
);

  logic              start;
  logic              take;
  logic              out_free;
  logic [SLOT_W-1:0] rd_addr;
  wr_t               wr;
  rd_t               rd;
  res_t              result;
  ctrl_stat_t        stat;

  assign req_ready = stat.idle;
  assign start     = req_valid && req_ready;
  assign out_free  = !res_valid || res_ready;
  assign take      = stat.done && out_free;

  lpht_store u_store (
    .clk     (clk),
    .rst     (rst),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd      (rd)
  );

  lpht_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .req     (req),
    .take    (take),
    .rd      (rd),
    .rd_addr (rd_addr),
    .wr      (wr),
    .result  (result),
    .stat    (stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (take) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
    if (take) begin
      res <= result;
    end
  end

  `ASSERT_CLK(a_busy_after_start, start |=> !req_ready, "ready stayed high after a request")
  `ASSERT_NEVER(a_take_while_idle, take && stat.idle, "result taken while sequencer idle")
  `ASSERT_CLK(a_insert_no_data, (res_valid && res.status == ST_INSERTED) |-> (res.data_out == '0), "insert result carries data")
  `ASSERT_CLK(a_miss_slot_zero, (res_valid && (res.status == ST_NOT_FOUND || res.status == ST_FULL)) |-> (res.slot == '0 && res.data_out == '0), "miss or full result not zero")

endmodule
